// ===== rtl/vhs_pkg.sv =====
// vote heatmap splatter: shared types, codes and reset values
// no dependencies; used by the cell store, the top level, the checker and the testbench
package vhs_pkg;

  localparam int unsigned POS_W      = 9;
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned SCORE_W    = 16;
  localparam int unsigned CELL_W     = 32;
  localparam int unsigned SIZE_W     = 10;
  localparam int unsigned SCALE_W    = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PROD_W     = CELL_W + SCALE_W;
  localparam int unsigned SCALE_FRAC = 24;

  localparam logic [SIZE_W-1:0]  ACTIVE_WIDTH_RST  = 10'd481;
  localparam logic [SIZE_W-1:0]  ACTIVE_HEIGHT_RST = 10'd353;
  localparam logic [SCALE_W-1:0] READ_SCALE_RST    = 32'd5214;

  typedef enum logic [0:0] {
    CMD_VOTE = 1'b0,
    CMD_READ = 1'b1
  } vhs_cmd_e;

  typedef enum logic [1:0] {
    CFG_ACTIVE_WIDTH  = 2'd0,
    CFG_ACTIVE_HEIGHT = 2'd1,
    CFG_READ_SCALE    = 2'd2
  } vhs_cfg_e;

  typedef struct packed {
    vhs_cmd_e                  command;
    logic [POS_W-1:0]          column;
    logic [POS_W-1:0]          row;
    logic signed [OFF_W-1:0]   disp_x;
    logic signed [OFF_W-1:0]   disp_y;
    logic [SCORE_W-1:0]        score;
  } vhs_req_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic              saturated;
  } vhs_res_t;

  // one word of the store: clip flag beside the q16.16 accumulator
  typedef struct packed {
    logic              clipped;
    logic [CELL_W-1:0] heat;
  } vhs_cell_t;

endpackage

// ===== rtl/vhs_stream_if.sv =====
// valid/ready stream channel carrying one request or result of type T
// no dependencies of its own; the payload type is bound at instantiation
interface vhs_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/vhs_store.sv =====
// heatmap cell store: single-port-write, single-port-read memory, registered read
// clears itself after reset with a sweep of one entry a cycle; uses vhs_pkg
module vhs_store #(
  parameter int unsigned AW = 18
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output vhs_pkg::vhs_cell_t  rd_data_o,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  vhs_pkg::vhs_cell_t  wr_data_i,
  output logic                clearing_o
);
  import vhs_pkg::*;

  localparam int unsigned DEPTH = 1 << AW;

  vhs_cell_t       mem [DEPTH];
  vhs_cell_t       rd_data_q;
  logic [AW-1:0]   clr_addr_q, clr_addr_d;
  logic            clearing_q, clearing_d;

  always_comb begin
    clr_addr_d = clr_addr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (&clr_addr_q) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clearing_q <= clearing_d;
    end
  end

  // sweep has the write port to itself while it runs
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

// ===== rtl/vote_heatmap_splatter.sv =====
// vote heatmap splatter top level: request decode, corner pipeline, read-out
// depends on vhs_pkg, vhs_stream_if and vhs_store
//
// usage
//   req_i carries votes and read-and-clear requests (valid/ready); res_o gives one
//   result per read request, none per vote. cfg_we_i/cfg_idx_i/cfg_data_i write the
//   active width, active height and read scale; write them only while idle.
// timing
//   a vote holds the issue stage: its four bilinear corners go one a cycle through a
//   read-modify-write of the single cell store (one read port, one write port).
//   a read request issues once; its result goes through the issue, s1, s2 and s3
//   registers to the result slot on res_o. a new request is taken as a vote's last corner issues.
//   corner pipeline: issue/first multiply, store read/second multiply,
//   accumulate and write back with the scale multiply (reads), round and saturate.
//   a write back to the cell that the following item reads in the same cycle is forwarded.
// reset
//   control clears at once; the store is swept to zero, one entry a cycle, over all
//   2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries (262144 at the defaults),
//   during which req_i is not ready. configuration writes are taken throughout.
// back-pressure
//   one result slot: while a read result is in flight or waits on a stalled
//   receiver, further read requests are held off; votes keep flowing.
module vote_heatmap_splatter #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512,
  parameter int unsigned FRAC_BITS  = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  vhs_stream_if.sink                         req_i,
  vhs_stream_if.source                       res_o,
  input  logic                               cfg_we_i,
  input  vhs_pkg::vhs_cfg_e                  cfg_idx_i,
  input  logic [vhs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import vhs_pkg::*;

  // address split: row bits above column bits
  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned AW  = CW + RW;
  // signed target width, room for position, offset and the +1 corner
  localparam int unsigned TW  = ((POS_W + FRAC_BITS > OFF_W) ? POS_W + FRAC_BITS : OFF_W) + 2;
  localparam int unsigned WW  = FRAC_BITS + 1;
  localparam int unsigned P1W = SCORE_W + WW;
  localparam int unsigned P2W = P1W + WW;
  localparam logic [WW-1:0]   W_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [P2W:0]    HALF   = (P2W+1)'(1) << (2*FRAC_BITS - 1);
  localparam logic [PROD_W-1:0] S_HALF = PROD_W'(1) << (SCALE_FRAC - 1);

  // configuration
  logic [SIZE_W-1:0]  act_w_q, act_h_q;
  logic [SCALE_W-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_w_q <= ACTIVE_WIDTH_RST;
      act_h_q <= ACTIVE_HEIGHT_RST;
      scale_q <= READ_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTIVE_WIDTH:  act_w_q <= cfg_data_i[SIZE_W-1:0];
        CFG_ACTIVE_HEIGHT: act_h_q <= cfg_data_i[SIZE_W-1:0];
        CFG_READ_SCALE:    scale_q <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline state
  logic             item_v_q, item_v_d;
  vhs_req_t         item_q;
  logic [1:0]       corner_q, corner_d;

  logic             s1_v_q, s1_en_q;
  vhs_cmd_e         s1_cmd_q;
  logic [AW-1:0]    s1_addr_q;
  logic [P1W-1:0]   s1_p1_q;
  logic [WW-1:0]    s1_wy_q;

  logic             s2_v_q, s2_en_q;
  vhs_cmd_e         s2_cmd_q;
  logic [AW-1:0]    s2_addr_q;
  logic [P2W-1:0]   s2_p2_q;
  logic             fwd_q;
  vhs_cell_t        fwd_cell_q;

  logic             s3_v_q, s3_en_q, s3_clip_q;
  logic [PROD_W-1:0] s3_prod_q;

  logic             out_v_q;
  vhs_res_t         out_q;

  logic             clearing;
  vhs_cell_t        rd_cell;

  // request acceptance
  logic issue_last, issue_free, read_busy, accept;

  assign issue_last = item_v_q && ((item_q.command == CMD_READ) || (corner_q == 2'd3));
  assign issue_free = !item_v_q || issue_last;
  // only one read result may be in flight or parked in the result slot
  assign read_busy  = (item_v_q && item_q.command == CMD_READ)
                    || (s1_v_q && s1_cmd_q == CMD_READ)
                    || (s2_v_q && s2_cmd_q == CMD_READ)
                    || s3_v_q || out_v_q;
  assign req_i.ready = !clearing && issue_free
                     && ((req_i.data.command == CMD_VOTE) || !read_busy);
  assign accept = req_i.valid && req_i.ready;

  always_comb begin
    item_v_d = item_v_q;
    corner_d = corner_q;
    if (accept) begin
      item_v_d = 1'b1;
      corner_d = 2'd0;
    end else if (issue_last) begin
      item_v_d = 1'b0;
    end else if (item_v_q) begin
      corner_d = corner_q + 2'd1;
    end
  end

  // issue stage: target point, corner coordinates and bilinear weights
  logic signed [TW-1:0] tx, ty, cx, cy, x, y;
  logic [FRAC_BITS-1:0] fx, fy;
  logic [WW-1:0]        wx, wy;
  logic                 in_range;
  logic [AW-1:0]        addr;

  always_comb begin
    tx = $signed(TW'(item_q.column) << FRAC_BITS)
       + $signed({{(TW-OFF_W){item_q.disp_x[OFF_W-1]}}, item_q.disp_x});
    ty = $signed(TW'(item_q.row) << FRAC_BITS)
       + $signed({{(TW-OFF_W){item_q.disp_y[OFF_W-1]}}, item_q.disp_y});
    fx = tx[FRAC_BITS-1:0];
    fy = ty[FRAC_BITS-1:0];
    cx = tx >>> FRAC_BITS;
    cy = ty >>> FRAC_BITS;
    if (item_q.command == CMD_READ) begin
      x = $signed(TW'(item_q.column));
      y = $signed(TW'(item_q.row));
    end else begin
      x = cx + $signed(TW'(corner_q[0]));
      y = cy + $signed(TW'(corner_q[1]));
    end
    wx = corner_q[0] ? WW'(fx) : W_ONE - WW'(fx);
    wy = corner_q[1] ? WW'(fy) : W_ONE - WW'(fy);
    in_range = !x[TW-1] && !y[TW-1]
             && ($unsigned(x) < TW'(act_w_q)) && ($unsigned(x) < TW'(MAX_WIDTH))
             && ($unsigned(y) < TW'(act_h_q)) && ($unsigned(y) < TW'(MAX_HEIGHT));
    addr = {y[RW-1:0], x[CW-1:0]};
  end

  // accumulate / clear stage
  vhs_cell_t       cell_cur, wr_cell;
  logic [P2W:0]    rnd;
  logic [CELL_W:0] sum;
  logic            wr_en;

  always_comb begin
    cell_cur = fwd_q ? fwd_cell_q : rd_cell;
    rnd      = {1'b0, s2_p2_q} + HALF;
    sum      = {1'b0, cell_cur.heat} + (CELL_W+1)'(rnd >> (2*FRAC_BITS));
    wr_en    = s2_v_q && s2_en_q;
    if (s2_cmd_q == CMD_READ) begin
      wr_cell = '0;
    end else if (sum[CELL_W]) begin
      wr_cell = '{clipped: 1'b1, heat: '1};
    end else begin
      wr_cell = '{clipped: cell_cur.clipped, heat: sum[CELL_W-1:0]};
    end
  end

  // round and saturate the scaled read value
  logic [PROD_W-1:0] scaled;
  logic              sc_ovf;
  vhs_res_t          res_d;

  always_comb begin
    scaled = s3_prod_q + S_HALF;
    sc_ovf = |scaled[PROD_W-1:SCALE_FRAC+CELL_W];
    if (!s3_en_q) begin
      res_d = '0;
    end else if (sc_ovf) begin
      res_d = '{cell_value: '1, saturated: 1'b1};
    end else begin
      res_d = '{cell_value: scaled[SCALE_FRAC+CELL_W-1:SCALE_FRAC], saturated: s3_clip_q};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
      corner_q <= 2'd0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      fwd_q    <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      item_v_q <= item_v_d;
      corner_q <= corner_d;
      s1_v_q   <= item_v_q;
      s2_v_q   <= s1_v_q;
      s3_v_q   <= s2_v_q && (s2_cmd_q == CMD_READ);
      // the write landing now is not seen by the read issued now
      fwd_q    <= s1_v_q && s1_en_q && wr_en && (s2_addr_q == s1_addr_q);
      if (s3_v_q) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= req_i.data;
    end
    s1_cmd_q   <= item_q.command;
    s1_en_q    <= in_range;
    s1_addr_q  <= addr;
    s1_p1_q    <= P1W'(item_q.score) * P1W'(wx);
    s1_wy_q    <= wy;
    s2_cmd_q   <= s1_cmd_q;
    s2_en_q    <= s1_en_q;
    s2_addr_q  <= s1_addr_q;
    s2_p2_q    <= P2W'(s1_p1_q) * P2W'(s1_wy_q);
    fwd_cell_q <= wr_cell;
    s3_en_q    <= s2_en_q;
    s3_clip_q  <= cell_cur.clipped;
    s3_prod_q  <= PROD_W'(cell_cur.heat) * PROD_W'(scale_q);
    if (s3_v_q) begin
      out_q <= res_d;
    end
  end

  vhs_store #(
    .AW (AW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (s1_v_q && s1_en_q),
    .rd_addr_i  (s1_addr_q),
    .rd_data_o  (rd_cell),
    .wr_en_i    (wr_en),
    .wr_addr_i  (s2_addr_q),
    .wr_data_i  (wr_cell),
    .clearing_o (clearing)
  );

  assign res_o.valid = out_v_q;
  assign res_o.data  = out_q;

  // the clearing sweep and the pipeline never share the write port
  a_no_write_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !wr_en)
    else $error("pipeline write during store clearing");

  // a finished read always finds the result slot empty
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q |-> !out_v_q)
    else $error("read result would overwrite a pending result");

  // at most one read in the pipeline
  a_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({s1_v_q && s1_cmd_q == CMD_READ, s2_v_q && s2_cmd_q == CMD_READ,
                s3_v_q}) <= 1)
    else $error("more than one read in flight");

  // a vote keeps its issue slot: req_i is not ready while its first corners issue
  a_vote_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.data.command == CMD_VOTE) |=> (item_v_q && !req_i.ready) ##1 !req_i.ready)
    else $error("vote issue slot released early");

endmodule

// ===== sim/vhs_splat_checker.sv =====
// vote heatmap splatter checker: watches request, result and register traffic,
// keeps its own copy of the heatmap and compares every read result
// depends on vhs_pkg for the request, result and register types
`timescale 1ns / 1ps

module vhs_splat_checker #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  input  logic                           req_ready_i,
  input  vhs_pkg::vhs_req_t              req_data_i,
  input  logic                           res_valid_i,
  input  logic                           res_ready_i,
  input  vhs_pkg::vhs_res_t              res_data_i,
  input  logic                           cfg_we_i,
  input  vhs_pkg::vhs_cfg_e              cfg_idx_i,
  input  logic [vhs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import vhs_pkg::*;

  // sparse copy of the store, absent entries read as zero
  logic [CELL_W-1:0]   heat_q16 [int unsigned];
  bit                  clip_flag [int unsigned];
  logic [SIZE_W-1:0]   width_reg;
  logic [SIZE_W-1:0]   height_reg;
  logic [SCALE_W-1:0]  scale_reg;
  vhs_res_t            reads_due [$];
  vhs_res_t            due;
  int                  mismatches;

  function automatic int cols_used();
    return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
  endfunction

  function automatic int rows_used();
    return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
  endfunction

  function automatic logic [CELL_W-1:0] heat_of(input int unsigned idx);
    return heat_q16.exists(idx) ? heat_q16[idx] : '0;
  endfunction

  // floor cell and fraction of pixel position plus signed q9.6 offset
  function automatic void split_axis(input logic [POS_W-1:0] pos,
                                     input logic signed [OFF_W-1:0] off,
                                     output int base, output int frac);
    int t;
    t    = (int'(pos) << FRAC_BITS) + int'(off);
    base = t >>> FRAC_BITS;
    frac = t & ((1 << FRAC_BITS) - 1);
  endfunction

  function automatic longint unsigned share_of(input logic [SCORE_W-1:0] score,
                                               input int wx, input int wy);
    longint unsigned v;
    v = 64'(score) * 64'(wx) * 64'(wy);
    return (v + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
  endfunction

  function automatic void add_share(input int x, input int y,
                                    input longint unsigned share);
    int unsigned     idx;
    longint unsigned sum;
    if (x < 0 || y < 0) return;
    if (x >= cols_used() || y >= rows_used()) return;
    if (share == 0) return;
    idx = int'(y) * MAX_WIDTH + x;
    sum = 64'(heat_of(idx)) + share;
    if (sum > 64'hFFFF_FFFF) begin
      heat_q16[idx]  = '1;
      clip_flag[idx] = 1'b1;
    end else begin
      heat_q16[idx] = sum[CELL_W-1:0];
    end
  endfunction

  function automatic void cast_vote(input vhs_req_t r);
    int x0, y0, dx, dy, one;
    one = 1 << FRAC_BITS;
    split_axis(r.column, r.disp_x, x0, dx);
    split_axis(r.row, r.disp_y, y0, dy);
    add_share(x0,     y0,     share_of(r.score, one - dx, one - dy));
    add_share(x0 + 1, y0,     share_of(r.score, dx,       one - dy));
    add_share(x0,     y0 + 1, share_of(r.score, one - dx, dy));
    add_share(x0 + 1, y0 + 1, share_of(r.score, dx,       dy));
  endfunction

  function automatic vhs_res_t read_and_clear(input vhs_req_t r);
    vhs_res_t        res;
    int unsigned     idx;
    longint unsigned prod, scaled;
    res = '0;
    if (int'(r.column) >= cols_used() || int'(r.row) >= rows_used()) return res;
    idx    = int'(r.row) * MAX_WIDTH + int'(r.column);
    prod   = 64'(heat_of(idx)) * 64'(scale_reg);
    scaled = (prod + (64'd1 << (SCALE_FRAC - 1))) >> SCALE_FRAC;
    res.saturated = clip_flag.exists(idx) ? clip_flag[idx] : 1'b0;
    if (scaled > 64'hFFFF_FFFF) begin
      scaled        = 64'hFFFF_FFFF;
      res.saturated = 1'b1;
    end
    res.cell_value = scaled[CELL_W-1:0];
    heat_q16[idx]  = '0;
    clip_flag[idx] = 1'b0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_q16.delete();
      clip_flag.delete();
      reads_due.delete();
      width_reg    = ACTIVE_WIDTH_RST;
      height_reg   = ACTIVE_HEIGHT_RST;
      scale_reg    = READ_SCALE_RST;
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (reads_due.size() == 0) begin
          $error("result with none due: cell_value %h saturated %b",
                 res_data_i.cell_value, res_data_i.saturated);
          mismatches++;
        end else begin
          due = reads_due.pop_front();
          if (res_data_i.cell_value !== due.cell_value) begin
            $error("cell_value: expected %h, actual %h", due.cell_value,
                   res_data_i.cell_value);
            mismatches++;
          end
          if (res_data_i.saturated !== due.saturated) begin
            $error("saturated: expected %b, actual %b", due.saturated,
                   res_data_i.saturated);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACTIVE_WIDTH:  width_reg  = cfg_data_i[SIZE_W-1:0];
          CFG_ACTIVE_HEIGHT: height_reg = cfg_data_i[SIZE_W-1:0];
          CFG_READ_SCALE:    scale_reg  = cfg_data_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i) begin
        if (req_data_i.command == CMD_VOTE) cast_vote(req_data_i);
        else reads_due.insert(reads_due.size(), read_and_clear(req_data_i));
      end
      fail_count_o <= mismatches;
      pending_o    <= reads_due.size();
    end
  end

endmodule

// ===== sim/tb_vote_heatmap_splatter.sv =====
// testbench top for the vote heatmap splatter: drives votes, reads and
// register writes, applies back-pressure and reports the verdict
// depends on vhs_pkg, vhs_stream_if, vote_heatmap_splatter and vhs_splat_checker
`timescale 1ns / 1ps

module tb_vote_heatmap_splatter;
  import vhs_pkg::*;

  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 160;   // random requests per register setting
  localparam int HOT_PHASE     = 3;     // small area, full scale: drive a cell to clip
  localparam int HAMMER_VOTES  = 300;   // enough full votes to overflow the scaled read
  localparam int HOLD_READS    = 40;
  localparam int LONG_HOLD     = 400;   // receiver stall, in cycles
  localparam int DRAIN_CYCLES  = 16;    // a vote gives no result, so let the pipe empty

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  vhs_cfg_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  // knobs of the request process; res_idle_on and long_hold_req also steer the result process
  bit                    idle_on;
  bit                    res_idle_on;
  bit                    long_hold_req;
  int unsigned           accepted_items;
  int unsigned           cur_w, cur_h;
  int unsigned           win_col, win_row;

  vhs_stream_if #(.T(vhs_req_t)) req_if ();
  vhs_stream_if #(.T(vhs_res_t)) res_if ();

  vote_heatmap_splatter u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  vhs_splat_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_data_i   (req_if.data),
    .res_valid_i  (res_if.valid),
    .res_ready_i  (res_if.ready),
    .res_data_i   (res_if.data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block stops answering (reset sweep alone is ~2.6 ms)
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- requests

  function automatic vhs_req_t vote_req(input logic [POS_W-1:0] col, row,
                                        input logic [OFF_W-1:0] ox, oy,
                                        input logic [SCORE_W-1:0] score);
    vhs_req_t r;
    r.command  = CMD_VOTE;
    r.column   = col;
    r.row      = row;
    r.disp_x   = ox;
    r.disp_y   = oy;
    r.score    = score;
    return r;
  endfunction

  // offsets and score are don't-care for a read, so fill them with noise
  function automatic vhs_req_t read_req(input logic [POS_W-1:0] col, row);
    vhs_req_t r;
    r = vote_req(col, row, OFF_W'($urandom), OFF_W'($urandom), SCORE_W'($urandom));
    r.command = CMD_READ;
    return r;
  endfunction

  // anything at all: full-range positions and offsets, either command
  function automatic vhs_req_t noise_req();
    vhs_req_t r;
    r = vote_req(POS_W'($urandom), POS_W'($urandom), OFF_W'($urandom),
                 OFF_W'($urandom), SCORE_W'($urandom));
    r.command = vhs_cmd_e'($urandom_range(0, 1));
    return r;
  endfunction

  // votes land within a few pixels of an 8x8 window so reads find heat
  function automatic vhs_req_t window_vote();
    int ox, oy;
    ox = int'($urandom_range(0, 383)) - 192;
    oy = int'($urandom_range(0, 383)) - 192;
    return vote_req(POS_W'(win_col + $urandom_range(0, 7)),
                    POS_W'(win_row + $urandom_range(0, 7)),
                    OFF_W'(ox), OFF_W'(oy), SCORE_W'($urandom));
  endfunction

  function automatic vhs_req_t window_read();
    return read_req(POS_W'(win_col + $urandom_range(0, 8)),
                    POS_W'(win_row + $urandom_range(0, 8)));
  endfunction

  // one request, after a random gap when idle_on is set; valid stays high if the next one follows at once
  task automatic send_request(input vhs_req_t r);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (!req_if.ready);
    accepted_items++;
  endtask

  // drop valid, wait for every read result, then let trailing votes finish
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // all three registers on consecutive edges, write enable held throughout
  task automatic set_config(input logic [SIZE_W-1:0] w, h,
                            input logic [SCALE_W-1:0] scale);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ACTIVE_WIDTH;
    cfg_data <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_idx  <= CFG_ACTIVE_HEIGHT;
    cfg_data <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_idx  <= CFG_READ_SCALE;
    cfg_data <= CFG_DATA_W'(scale);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  // window placed inside the area in use (clamped to the store size), at its origin where that is narrower than 8
  task automatic pick_window();
    int unsigned span_w, span_h;
    span_w = (cur_w > 512) ? 512 : cur_w;
    span_h = (cur_h > 512) ? 512 : cur_h;
    win_col = $urandom_range(0, (span_w > 8) ? span_w - 8 : 0);
    win_row = $urandom_range(0, (span_h > 8) ? span_h - 8 : 0);
  endtask

  // typical traffic: a cluster of votes, then read-and-clear of cells around it,
  // with about one request in six replaced by noise
  task automatic splat_burst();
    int unsigned n_votes, n_reads;
    n_votes     = $urandom_range(2, 16);
    n_reads     = $urandom_range(2, 10);
    idle_on     = ($urandom_range(0, 4) != 0);
    res_idle_on = ($urandom_range(0, 4) != 0);
    pick_window();
    repeat (n_votes)
      send_request(($urandom_range(0, 5) == 0) ? noise_req() : window_vote());
    repeat (n_reads)
      send_request(($urandom_range(0, 5) == 0) ? noise_req() : window_read());
  endtask

  // pile whole-pixel votes on one cell until the scaled read clips, then hold
  // the result side off while reads keep coming so the input backs up
  task automatic hot_spot();
    int unsigned hot_col, hot_row, kx, ky;
    hot_col     = $urandom_range(0, 15);
    hot_row     = $urandom_range(0, 8);
    idle_on     = 1'b0;
    res_idle_on = 1'b0;
    repeat (HAMMER_VOTES) begin
      // integer offsets only, so the three other corners carry zero weight
      kx = $urandom_range(0, (hot_col < 3) ? hot_col : 3);
      ky = $urandom_range(0, (hot_row < 3) ? hot_row : 3);
      send_request(vote_req(POS_W'(hot_col - kx), POS_W'(hot_row - ky),
                            OFF_W'(kx << 6), OFF_W'(ky << 6), 16'hFFFF));
    end
    send_request(read_req(POS_W'(hot_col), POS_W'(hot_row)));
    long_hold_req = 1'b1;
    repeat (HOLD_READS)
      send_request(read_req(POS_W'($urandom_range(0, 17)), POS_W'($urandom_range(0, 10))));
  endtask

  // ----------------------------------------------------------- result side
  // own stall per result; on request one long hold counted here
  initial begin
    int unsigned stall;
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = res_idle_on ? $urandom_range(0, 14) : 0;
        if (stall != 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  // --------------------------------------------------------------- stimulus
  initial begin
    logic [SIZE_W-1:0]  w, h;
    logic [SCALE_W-1:0] scale;
    int unsigned        phase_end;

    rst_n          = 1'b0;
    req_if.valid  <= 1'b0;
    req_if.data   <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_ACTIVE_WIDTH;
    cfg_data      <= '0;
    idle_on        = 1'b1;
    res_idle_on    = 1'b1;
    long_hold_req  = 1'b0;
    accepted_items = 0;
    cur_w          = ACTIVE_WIDTH_RST;
    cur_h          = ACTIVE_HEIGHT_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed, at reset settings (481 x 353); the first request also waits
    // out the store sweep after reset
    send_request(vote_req(0, 0, 16'h0000, 16'h0000, 16'hFFFF));   // whole score on one cell
    send_request(read_req(0, 0));
    send_request(read_req(0, 0));                                  // cleared by the read before
    send_request(vote_req(0, 0, 16'h8000, 16'h8000, 16'hFFFF));   // all corners left/above
    send_request(vote_req(511, 511, 16'h7FFF, 16'h7FFF, 16'hFFFF)); // far outside
    send_request(vote_req(480, 352, 16'h0020, 16'h0020, 16'hFFFF)); // straddles the edge
    send_request(read_req(480, 352));
    send_request(read_req(481, 352));                              // just outside width
    send_request(read_req(480, 353));                              // just outside height
    send_request(vote_req(10, 10, 16'h0000, 16'h0000, 16'h0000));  // zero score
    send_request(read_req(10, 10));
    send_request(vote_req(5, 5, 16'hFFFF, 16'hFFFF, 16'h8000));    // one lsb back: floor to 4
    send_request(read_req(4, 4));
    send_request(read_req(5, 4));
    send_request(read_req(4, 5));
    send_request(read_req(5, 5));
    send_request(vote_req(100, 200, 16'h7FFF, 16'h8000, 16'h0001)); // extreme offsets
    send_request(vote_req(2, 3, 16'd100, 16'hFFBA, 16'hABCD));      // mixed fractions
    send_request(read_req(3, 1));
    send_request(read_req(4, 2));
    send_request(read_req(3, 2));
    send_request(read_req(511, 511));
    wait_idle();

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1: begin w = 512; h = 512; scale = 32'h0100_0000; end  // full store, unity
          2: begin w = 1;   h = 1;   scale = 32'h0000_0000; end  // single cell, zero scale
          3: begin w = 16;  h = 9;   scale = 32'hFFFF_FFFF; end  // hot spot
          4: begin w = 0;   h = 300; scale = READ_SCALE_RST; end // no columns at all
          5: begin w = 1023; h = 0;  scale = $urandom; end       // width above the store
          6: begin
            w = SIZE_W'($urandom_range(2, 512));
            h = SIZE_W'($urandom_range(2, 512));
            scale = $urandom;
          end
          7: begin w = 512; h = 1;   scale = 32'h0100_0000; end
          default: begin w = 7; h = 512; scale = 32'hFFFF_FFFF; end
        endcase
        set_config(w, h, scale);
      end
      if (p == HOT_PHASE) hot_spot();
      phase_end = accepted_items + PHASE_ITEMS;
      while (accepted_items < phase_end) splat_burst();
      // sender stops here until every read has answered
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vhs_pkg.sv
rtl/vhs_stream_if.sv
rtl/vhs_store.sv
rtl/vote_heatmap_splatter.sv
sim/vhs_splat_checker.sv
sim/tb_vote_heatmap_splatter.sv
